FILE: sv/lgs_pkg.sv
package lgs_pkg;

	localparam int GRID_SIZE = 16;
	localparam int ROW_W     = $clog2(GRID_SIZE);

	// packed widths of the stream payloads
	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 8;

	typedef enum logic [1:0] {
		FUNC_WRITE = 2'd0,
		FUNC_READ  = 2'd1,
		FUNC_STEP  = 2'd2,
		FUNC_BAD   = 2'd3
	} func_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ACCESS,
		ST_LOAD0,
		ST_LOAD1,
		ST_LOADL,
		ST_CELL,
		ST_WROW,
		ST_FETCH,
		ST_DONE
	} state_t;

	typedef logic [GRID_SIZE-1:0] row_t;

	// B3/S23 rule on an 8-neighbor window
	function automatic logic life_rule(input logic alive, input logic [7:0] nbr);
		logic [3:0] n;
		n = 4'(nbr[0]) + 4'(nbr[1]) + 4'(nbr[2]) + 4'(nbr[3])
		  + 4'(nbr[4]) + 4'(nbr[5]) + 4'(nbr[6]) + 4'(nbr[7]);
		return alive ? (n == 4'd2 || n == 4'd3) : (n == 4'd3);
	endfunction

endpackage

FILE: sv/lgs_ram.sv
module lgs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

FILE: sv/life_grid_generation_step_core.sv
// channel | dir | tdata bits (low first)                       | per item
// s_axis  | in  | func[1:0] row[5:2] col[9:6] cell_in[10] 0[15:11] | one request
// m_axis  | out | cell_out[0] status[1] 0[7:2]                 | one result
//
// Grid lives in a row-wide RAM (one row per word) with a valid bit per row,
// so reset clears it at once; a row never written reads as all dead.
// Read and write pass through an access state on the way to done, an unknown
// func goes straight to done; a generation is paced by the single cell-rule
// unit that evaluates one cell per cycle over a sliding three-row window.
// s_tready is high only in idle, so requests are taken one at a time; a stalled m_axis
// holds the finished result and the next request waits in its done state.
module life_grid_generation_step_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// func[1:0], row[5:2], col[9:6], cell_in[10], zero pad
	input  logic [lgs_pkg::IN_TDATA_W-1:0]     s_tdata,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// cell_out[0], status[1], zero pad
	output logic [lgs_pkg::OUT_TDATA_W-1:0]    m_tdata
);
	import lgs_pkg::*;

	state_t state_q, state_d;

	func_t            op_func_q;
	logic [ROW_W-1:0] op_row_q, op_col_q;
	logic             op_val_q;
	logic             op_inside;

	logic [GRID_SIZE-1:0] vld_q;
	logic [ROW_W-1:0]     rd_row_q;
	row_t                 rd_data, row_data;

	row_t row0_q, prv_q, cur_q, nxt_q, new_q;
	logic [ROW_W-1:0] r_q, c_q, c_lf, c_rt;
	logic             new_bit;

	logic             ram_we, ram_re;
	logic [ROW_W-1:0] ram_waddr, ram_raddr;
	row_t             ram_wdata;

	logic res_cell_q, res_stat_q, m_valid_q;
	logic rd_bit_q;
	logic res_stat_d;
	logic accept, out_free;

	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_valid_q || m_tready;
	assign row_data = vld_q[rd_row_q] ? rd_data : '0;

	assign op_inside = (32'(s_tdata[5:2]) < GRID_SIZE) && (32'(s_tdata[9:6]) < GRID_SIZE);

	assign c_lf = (c_q == '0) ? ROW_W'(GRID_SIZE - 1) : c_q - 1'b1;
	assign c_rt = (c_q == ROW_W'(GRID_SIZE - 1)) ? '0 : c_q + 1'b1;

	assign new_bit = life_rule(cur_q[c_q], {prv_q[c_lf], prv_q[c_q], prv_q[c_rt],
		cur_q[c_lf], cur_q[c_rt], nxt_q[c_lf], nxt_q[c_q], nxt_q[c_rt]});

	lgs_ram #(.WIDTH(GRID_SIZE), .DEPTH(GRID_SIZE)) u_grid (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (ram_wdata),
		.rd_en   (ram_re),
		.rd_addr (ram_raddr),
		.rd_data (rd_data)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					priority if (func_t'(s_tdata[1:0]) == FUNC_STEP) state_d = ST_LOAD0;
					else if (func_t'(s_tdata[1:0]) == FUNC_BAD || !op_inside) state_d = ST_DONE;
					else state_d = ST_ACCESS;
				end
			end
			ST_ACCESS: state_d = ST_DONE;
			ST_LOAD0:  state_d = ST_LOAD1;
			ST_LOAD1:  state_d = ST_LOADL;
			ST_LOADL:  state_d = ST_CELL;
			ST_CELL: begin
				if (c_q == ROW_W'(GRID_SIZE - 1)) state_d = ST_WROW;
			end
			ST_WROW: begin
				priority if (r_q == ROW_W'(GRID_SIZE - 1)) state_d = ST_DONE;
				else if (r_q == ROW_W'(GRID_SIZE - 2)) state_d = ST_CELL;
				else state_d = ST_FETCH;
			end
			ST_FETCH: state_d = ST_CELL;
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		s_tready   = 1'b0;
		ram_we     = 1'b0;
		ram_waddr  = r_q;
		ram_wdata  = new_q;
		ram_re     = 1'b0;
		ram_raddr  = '0;
		res_stat_d = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready  = 1'b1;
				ram_re    = accept;
				// a generation starts its window load with row 0
				ram_raddr = (func_t'(s_tdata[1:0]) == FUNC_STEP) ? '0 : ROW_W'(s_tdata[5:2]);
			end
			ST_ACCESS: begin
				if (op_func_q == FUNC_WRITE) begin
					ram_we    = 1'b1;
					ram_waddr = op_row_q;
					ram_wdata = row_data;
					ram_wdata[op_col_q] = op_val_q;
				end
			end
			ST_LOAD0: begin
				ram_re    = 1'b1;
				ram_raddr = ROW_W'(1);
			end
			ST_LOAD1: begin
				ram_re    = 1'b1;
				ram_raddr = ROW_W'(GRID_SIZE - 1);
			end
			ST_WROW: begin
				ram_we    = 1'b1;
				ram_re    = (r_q < ROW_W'(GRID_SIZE - 2));
				ram_raddr = r_q + ROW_W'(2);
			end
			ST_DONE: begin
				res_stat_d = (op_func_q == FUNC_BAD);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			vld_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ram_we) begin
				vld_q[ram_waddr] <= 1'b1;
			end
			if (state_q == ST_DONE && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ram_re) begin
			rd_row_q <= ram_raddr;
		end
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					op_func_q <= func_t'(s_tdata[1:0]);
					op_row_q  <= ROW_W'(s_tdata[5:2]);
					op_col_q  <= ROW_W'(s_tdata[9:6]);
					op_val_q  <= s_tdata[10];
					rd_bit_q  <= 1'b0;
				end
			end
			ST_ACCESS: begin
				if (op_func_q == FUNC_READ) rd_bit_q <= row_data[op_col_q];
			end
			ST_LOAD0: begin
				row0_q <= row_data;
				cur_q  <= row_data;
			end
			ST_LOAD1: begin
				nxt_q <= row_data;
			end
			ST_LOADL: begin
				prv_q <= row_data;
				r_q   <= '0;
				c_q   <= '0;
			end
			ST_CELL: begin
				new_q[c_q] <= new_bit;
				c_q <= c_q + 1'b1;
			end
			ST_WROW: begin
				prv_q <= cur_q;
				cur_q <= nxt_q;
				c_q   <= '0;
				if (r_q == ROW_W'(GRID_SIZE - 2)) begin
					// old row 0 is already overwritten in RAM
					nxt_q <= row0_q;
					r_q   <= r_q + 1'b1;
				end
			end
			ST_FETCH: begin
				nxt_q <= row_data;
				r_q   <= r_q + 1'b1;
			end
			ST_DONE: begin
				if (out_free) begin
					res_cell_q <= rd_bit_q;
					res_stat_q <= res_stat_d;
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {{(OUT_TDATA_W - 2){1'b0}}, res_stat_q, res_cell_q};

endmodule

FILE: sv/lgs_chk.sv
module lgs_chk (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic [lgs_pkg::IN_TDATA_W-1:0]  s_tdata,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [lgs_pkg::OUT_TDATA_W-1:0] m_tdata
);
	import lgs_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("ready right after a request");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[OUT_TDATA_W-1:2] == '0)
		else $error("result padding not zero");

	a_bad_no_cell: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
		else $error("cell_out set with unknown-func status");

	a_bad_fast: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tdata[1:0] == FUNC_BAD |=> !m_tvalid || m_tready
		|| $past(m_tvalid))
		else $error("unknown func result late");

endmodule

bind life_grid_generation_step_core lgs_chk u_lgs_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

FILE: tb/sv/life_grid_checker.sv
`timescale 1ns / 100ps

// Watches both stream channels, keeps its own copy of the torus grid and
// compares every result against the oldest outstanding request.
module life_grid_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	input  logic                           s_tready,
	input  logic [lgs_pkg::IN_TDATA_W-1:0] s_tdata,
	input  logic                           m_tvalid,
	input  logic                           m_tready,
	input  logic [lgs_pkg::OUT_TDATA_W-1:0] m_tdata,
	output int                             fail_count,
	output int                             pending,
	output int                             results_seen
);
	import lgs_pkg::*;

	typedef struct packed {
		logic cell_out;
		logic status;
	} life_result_t;

	row_t         life_grid [GRID_SIZE];
	life_result_t expected_results [$];
	life_result_t want;

	// one generation of B3/S23 with wrap-around on both axes
	function automatic void advance_grid();
		row_t nxt [GRID_SIZE];
		int   n;
		for (int r = 0; r < GRID_SIZE; r++) begin
			for (int c = 0; c < GRID_SIZE; c++) begin
				n = 0;
				for (int dr = -1; dr <= 1; dr++) begin
					for (int dc = -1; dc <= 1; dc++) begin
						if (dr != 0 || dc != 0)
							n += life_grid[(r + dr + GRID_SIZE) % GRID_SIZE]
								[(c + dc + GRID_SIZE) % GRID_SIZE];
					end
				end
				nxt[r][c] = life_grid[r][c] ? (n == 2 || n == 3) : (n == 3);
			end
		end
		life_grid = nxt;
	endfunction

	function automatic life_result_t apply_request(input logic [IN_TDATA_W-1:0] d);
		func_t        f;
		int           r;
		int           c;
		life_result_t res;
		f   = func_t'(d[1:0]);
		r   = int'(d[5:2]);
		c   = int'(d[9:6]);
		res = '0;
		case (f)
			FUNC_WRITE: begin
				if (r < GRID_SIZE && c < GRID_SIZE)
					life_grid[r][c] = d[10];
			end
			FUNC_READ: begin
				if (r < GRID_SIZE && c < GRID_SIZE)
					res.cell_out = life_grid[r][c];
			end
			FUNC_STEP: advance_grid();
			default: res.status = 1'b1;
		endcase
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < GRID_SIZE; r++)
				life_grid[r] = '0;
			expected_results.delete();
			fail_count   = 0;
			results_seen = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0) begin
					$error("result with no request outstanding: tdata %h", m_tdata);
					fail_count++;
				end else begin
					want = expected_results.pop_front();
					results_seen++;
					if (m_tdata[0] !== want.cell_out) begin
						$error("cell_out mismatch: expected %0d, got %0d",
							want.cell_out, m_tdata[0]);
						fail_count++;
					end
					if (m_tdata[1] !== want.status) begin
						$error("status mismatch: expected %0d, got %0d",
							want.status, m_tdata[1]);
						fail_count++;
					end
					if (m_tdata[OUT_TDATA_W-1:2] !== '0) begin
						$error("pad mismatch: expected 0, got %h",
							m_tdata[OUT_TDATA_W-1:2]);
						fail_count++;
					end
				end
			end
			if (s_tvalid && s_tready)
				expected_results.push_back(apply_request(s_tdata));
		end
		pending = expected_results.size();
	end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import lgs_pkg::*;

	logic                   clk      = 1'b0;
	logic                   arst_n   = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata  = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;

	int fail_count;
	int pending;
	int results_seen;
	int sent = 0;
	int op_count [4] = '{0, 0, 0, 0};

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	life_grid_generation_step_core uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	life_grid_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.fail_count  (fail_count),
		.pending     (pending),
		.results_seen(results_seen)
	);

	// offer one request and hold it until taken; random gaps except in a steady window
	task automatic send_request(input func_t f, input int r, input int c, input bit v);
		s_tdata  <= {5'b0, v, 4'(c), 4'(r), f};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		op_count[f]++;
		sent++;
		if (!(sent >= 400 && sent < 600) && $urandom_range(99) < 13) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	// stop offering and wait until every request has its result
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
	endtask

	// result sink: random stalls, a steady window, two long hold-offs
	initial begin : sink
		int cyc;
		cyc = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			cyc++;
			if (cyc == 2500 || cyc == 20000) begin
				m_tready <= 1'b0;
				repeat (700) @(posedge clk);
				cyc += 700;
			end else if (cyc >= 8000 && cyc < 12000) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= ($urandom_range(99) >= 13);
			end
		end
	end

	initial begin : stimulus
		int  org_r;
		int  org_c;
		bit  paused;
		localparam int L = GRID_SIZE - 1;
		paused = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// corners first: on the torus the four corners form one 2x2 block
		send_request(FUNC_READ, 0, 0, 1'b1);
		send_request(FUNC_WRITE, 0, 0, 1'b1);
		send_request(FUNC_WRITE, L, L, 1'b1);
		send_request(FUNC_WRITE, 0, L, 1'b1);
		send_request(FUNC_WRITE, L, 0, 1'b1);
		send_request(FUNC_STEP, L, L, 1'b1);
		send_request(FUNC_READ, 0, 0, 1'b0);
		send_request(FUNC_READ, L, L, 1'b1);
		send_request(FUNC_READ, 0, L, 1'b1);
		send_request(FUNC_READ, L, 0, 1'b0);
		send_request(FUNC_READ, 7, 8, 1'b1);
		send_request(FUNC_BAD, L, L, 1'b1);
		send_request(FUNC_BAD, 0, 0, 1'b0);
		send_request(FUNC_READ, 0, 0, 1'b0);
		send_request(FUNC_WRITE, L, L, 1'b0);
		send_request(FUNC_READ, L, L, 1'b0);
		// three live neighbors bring the removed corner back
		send_request(FUNC_STEP, 0, 0, 1'b0);
		send_request(FUNC_READ, L, L, 1'b0);
		send_request(FUNC_READ, 0, L, 1'b0);
		send_request(FUNC_WRITE, 5, 10, 1'b0);

		while (sent < 1350) begin
			if ($urandom_range(99) < 75) begin
				// seed a small pattern, then run it and probe around it
				org_r = $urandom_range(L);
				org_c = $urandom_range(L);
				repeat ($urandom_range(4, 14))
					send_request(FUNC_WRITE, (org_r + $urandom_range(4)) % GRID_SIZE,
						(org_c + $urandom_range(4)) % GRID_SIZE, $urandom_range(99) < 70);
				repeat ($urandom_range(1, 5)) begin
					send_request(FUNC_STEP, $urandom_range(L), $urandom_range(L),
						1'($urandom_range(1)));
					repeat ($urandom_range(2, 8))
						send_request(FUNC_READ,
							(org_r + $urandom_range(8) + GRID_SIZE - 2) % GRID_SIZE,
							(org_c + $urandom_range(8) + GRID_SIZE - 2) % GRID_SIZE,
							1'($urandom_range(1)));
				end
			end else begin
				repeat ($urandom_range(1, 6))
					send_request(func_t'($urandom_range(3)), $urandom_range(L),
						$urandom_range(L), 1'($urandom_range(1)));
			end
			if (!paused && sent >= 900) begin
				wait_drained();
				paused = 1'b1;
			end
		end

		wait_drained();
		repeat (30) @(posedge clk);
		$display("Sent %0d requests: %0d writes, %0d reads, %0d generations, %0d unknown codes",
			sent, op_count[FUNC_WRITE], op_count[FUNC_READ], op_count[FUNC_STEP],
			op_count[FUNC_BAD]);
		$display("Checked %0d results against the predicted grid, %0d mismatches",
			results_seen, fail_count);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin : watchdog
		#30_000_000;
		$display("Timeout with %0d results outstanding", pending);
		$display("status: fail");
		$finish;
	end

endmodule
